/* rtl/ksl_pkg.sv */
// ----------------------------------------------------------------------------
// ksl_pkg
// Shared types and codes for the keyed sequential list table.
// ----------------------------------------------------------------------------
`default_nettype none

package ksl_pkg;

    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_LOOKUP = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_DUP     = 2'd2;
    localparam status_t ST_MISSING = 2'd3;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [KEY_W-1:0] key;
        action_t          action;
    } req_t;

    typedef struct packed {
        logic [PAY_W-1:0] found;
        status_t          status;
    } res_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RD    = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_SH_RD = 7'b0001000,
        S_SH_WR = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_SPARE = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

/* rtl/ksl_ram.sv */
// ----------------------------------------------------------------------------
// ksl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ksl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/ksl_engine.sv */
// ----------------------------------------------------------------------------
// ksl_engine
// Sequencer around one shared key comparator and the entry RAM: scan, append,
// and shift-down on delete.
// ----------------------------------------------------------------------------
`default_nettype none

module ksl_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           start,
    input  wire ksl_pkg::req_t                  req,
    input  wire logic                           out_free,
    output logic                                idle,
    output logic                                done,
    output ksl_pkg::res_t                       res,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]    count
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = ksl_pkg::KEY_W + ksl_pkg::PAY_W;

    ksl_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   count_reg, count_next;
    ksl_pkg::req_t   req_reg, req_next;
    ksl_pkg::res_t   res_reg, res_next;

    logic [CW-1:0]   idx_inc;
    logic            key_hit;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [EW-1:0]   ram_wdata, ram_rdata;

    ksl_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_inc = idx_reg + CW'(1);
    // the one shared compare unit
    assign key_hit = (ram_rdata[ksl_pkg::KEY_W-1:0] == req_reg.key);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg[AW-1:0];
        ram_wdata  = {req_reg.payload, req_reg.key};
        ram_raddr  = idx_reg[AW-1:0];
        done       = 1'b0;

        unique case (state_reg)
            ksl_pkg::S_IDLE: begin
                if (start) begin
                    req_next        = req;
                    idx_next        = '0;
                    res_next.status = ksl_pkg::ST_OK;
                    res_next.found  = '0;
                    case (req.action)
                        ksl_pkg::ACT_INSERT: begin
                            if (count_reg == CW'(TABLE_DEPTH)) begin
                                res_next.status = ksl_pkg::ST_FULL;
                                state_next      = ksl_pkg::S_DONE;
                            end else begin
                                state_next = ksl_pkg::S_RD;
                            end
                        end
                        ksl_pkg::ACT_LOOKUP,
                        ksl_pkg::ACT_DELETE: state_next = ksl_pkg::S_RD;
                        default:             state_next = ksl_pkg::S_DONE;
                    endcase
                end
            end
            ksl_pkg::S_RD: begin
                if (idx_reg == count_reg) begin
                    // scan ran off the end: key absent
                    if (req_reg.action == ksl_pkg::ACT_INSERT) begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end else begin
                        res_next.status = ksl_pkg::ST_MISSING;
                    end
                    state_next = ksl_pkg::S_DONE;
                end else begin
                    state_next = ksl_pkg::S_CMP;
                end
            end
            ksl_pkg::S_CMP: begin
                if (key_hit) begin
                    case (req_reg.action)
                        ksl_pkg::ACT_INSERT: begin
                            res_next.status = ksl_pkg::ST_DUP;
                            state_next      = ksl_pkg::S_DONE;
                        end
                        ksl_pkg::ACT_LOOKUP: begin
                            res_next.found = ram_rdata[EW-1:ksl_pkg::KEY_W];
                            state_next     = ksl_pkg::S_DONE;
                        end
                        default: state_next = ksl_pkg::S_SH_RD;
                    endcase
                end else begin
                    idx_next   = idx_inc;
                    state_next = ksl_pkg::S_RD;
                end
            end
            ksl_pkg::S_SH_RD: begin
                if (idx_inc == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = ksl_pkg::S_DONE;
                end else begin
                    ram_raddr  = idx_inc[AW-1:0];
                    state_next = ksl_pkg::S_SH_WR;
                end
            end
            ksl_pkg::S_SH_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc;
                state_next = ksl_pkg::S_SH_RD;
            end
            ksl_pkg::S_DONE: begin
                done = out_free;
                if (out_free) begin
                    state_next = ksl_pkg::S_IDLE;
                end
            end
            default: state_next = ksl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ksl_pkg::S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign idle  = (state_reg == ksl_pkg::S_IDLE);
    assign res   = res_reg;
    assign count = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_cmp_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ksl_pkg::S_CMP |-> $past(state_reg) == ksl_pkg::S_RD)
        else $error("compare without a preceding read");

    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(count_reg) |->
            $past(state_reg) == ksl_pkg::S_RD || $past(state_reg) == ksl_pkg::S_SH_RD)
        else $error("entry count changed outside append or delete end");

    a_done_release: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ksl_pkg::S_DONE && out_free |=> state_reg == ksl_pkg::S_IDLE)
        else $error("result handed off but sequencer did not return to idle");

endmodule

`default_nettype wire

/* rtl/keyed_sequential_list_table.sv */
// The scan reads each entry (S_RD) and then compares its key (S_CMP), in turn
//   from the first entry; on delete the shift-down takes over from the rest
//   of the scan. One request is worked at a time; a result waits in S_DONE
//   while m_tready stalls the output, and s_tready is low while a request is
//   worked.
// Reset clears the entry count and control; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
// keyed_sequential_list_table
// Bounded table of unique keys with payloads: insert, lookup, delete.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_sequential_list_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // action[1:0], key[33:2], payload[65:34], zero pad to 72
    input  wire logic [71:0]               s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // status[1:0], found_payload[33:2], entry_count[34+:CW], zero pad to bytes
    output logic [((2 + 32 + $clog2(TABLE_DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW    = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W = ((2 + 32 + CW + 7) / 8) * 8;

    ksl_pkg::req_t  req;
    ksl_pkg::res_t  res;
    logic [CW-1:0]  count;
    logic           idle, done, start, out_free;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    assign req.action  = s_tdata[ksl_pkg::ACTION_W-1:0];
    assign req.key     = s_tdata[ksl_pkg::ACTION_W +: ksl_pkg::KEY_W];
    assign req.payload = s_tdata[ksl_pkg::ACTION_W + ksl_pkg::KEY_W +: ksl_pkg::PAY_W];

    assign s_tready = idle;
    assign start    = s_tvalid && idle;
    assign out_free = !m_tvalid_reg || m_tready;

    ksl_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .req      (req),
        .out_free (out_free),
        .idle     (idle),
        .done     (done),
        .res      (res),
        .count    (count)
    );

    // output register: holds a result while the next request is taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'({count, res.found, res.status});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* sim/keyed_sequential_list_table_checker.sv */
// ----------------------------------------------------------------------------
// keyed_sequential_list_table_checker
// Watches both stream channels of the key table, keeps its own copy of the
// table contents, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module keyed_sequential_list_table_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int RES_W       = 48
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [71:0]      s_tdata,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [RES_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        ksl_pkg::status_t status;
        logic [31:0]      found;
        logic [6:0]       count;
    } outcome_t;

    // shadow table, entries packed in arrival order
    logic [31:0] shadow_keys[$];
    logic [31:0] shadow_payloads[$];
    outcome_t    awaited_outcomes[$];

    function automatic outcome_t apply_request(input ksl_pkg::action_t act,
                                               input logic [31:0] k,
                                               input logic [31:0] p);
        outcome_t o;
        int       pos;
        o.status = ksl_pkg::ST_OK;
        o.found  = '0;
        pos = 0;
        while (pos < shadow_keys.size() && shadow_keys[pos] != k)
            pos++;
        case (act)
            ksl_pkg::ACT_INSERT: begin
                // full check wins over the duplicate check
                if (shadow_keys.size() >= TABLE_DEPTH)
                    o.status = ksl_pkg::ST_FULL;
                else if (pos < shadow_keys.size())
                    o.status = ksl_pkg::ST_DUP;
                else begin
                    shadow_keys.push_back(k);
                    shadow_payloads.push_back(p);
                end
            end
            ksl_pkg::ACT_LOOKUP: begin
                if (pos < shadow_keys.size())
                    o.found = shadow_payloads[pos];
                else
                    o.status = ksl_pkg::ST_MISSING;
            end
            ksl_pkg::ACT_DELETE: begin
                if (pos < shadow_keys.size()) begin
                    shadow_keys.delete(pos);
                    shadow_payloads.delete(pos);
                end else
                    o.status = ksl_pkg::ST_MISSING;
            end
            default: ;
        endcase
        o.count = 7'(shadow_keys.size());
        return o;
    endfunction

    always @(posedge aclk) begin
        outcome_t         want;
        ksl_pkg::status_t got_status;
        if (!aresetn) begin
            shadow_keys.delete();
            shadow_payloads.delete();
            awaited_outcomes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[1:0];
                if (awaited_outcomes.size() == 0) begin
                    $error("response with no request outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (got_status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got_status);
                        fail_count++;
                    end
                    if (m_tdata[33:2] != want.found) begin
                        $error("found_payload: expected %h, got %h", want.found,
                               m_tdata[33:2]);
                        fail_count++;
                    end
                    if (m_tdata[40:34] != want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               m_tdata[40:34]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_outcomes.push_back(apply_request(s_tdata[1:0], s_tdata[33:2],
                                                         s_tdata[65:34]));
        end
        pending = awaited_outcomes.size();
    end

endmodule

/* sim/keyed_sequential_list_table_tb.sv */
// ----------------------------------------------------------------------------
// keyed_sequential_list_table_tb
// Drives insert, lookup and delete requests into the key table with random
// stalls on both channels; a checker beside the block predicts the responses.
// ----------------------------------------------------------------------------
module keyed_sequential_list_table_tb;

    localparam int               TABLE_DEPTH  = 64;
    localparam int               RES_W        = ((2 + 32 + $clog2(TABLE_DEPTH+1) + 7) / 8) * 8;
    localparam int               RANDOM_ITEMS = 1930;
    localparam int               PHASE_LEN    = 200;
    localparam int               POOL_SIZE    = 80;
    localparam int               DRAIN_CYCLES = 300;
    localparam int               STALL_LIMIT  = 4000;
    localparam ksl_pkg::action_t ACT_UNUSED   = 2'd3;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [71:0]      s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [RES_W-1:0] m_tdata;
    int               fail_count;
    int               pending;

    logic             no_idle;
    int               quiet_cycles;
    int               action_seen[4];
    int               status_seen[4];
    logic [31:0]      key_pool[POOL_SIZE];

    keyed_sequential_list_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    keyed_sequential_list_table_checker #(.TABLE_DEPTH(TABLE_DEPTH), .RES_W(RES_W)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 8);
    end

    // watchdog on cycles with no request or response moving
    always @(posedge aclk) begin
        if (m_tvalid && m_tready)
            status_seen[m_tdata[1:0]]++;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no traffic for %0d cycles, %0d responses missing",
                     STALL_LIMIT, pending);
            $display("keyed_sequential_list_table_tb: errors");
            $finish;
        end
    end

    task automatic issue_request(input ksl_pkg::action_t act, input logic [31:0] k,
                                 input logic [31:0] p);
        @(negedge aclk);
        if (!no_idle && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p, k, act};
        action_seen[act]++;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    initial begin
        ksl_pkg::action_t act;
        logic [31:0]      k;
        int               roll;
        int               ins_cursor;
        int               del_cursor;
        logic             filling;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        no_idle      = 1'b0;
        foreach (key_pool[j]) key_pool[j] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h0000_0001;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table, extremes, duplicate, head and tail removal
        issue_request(ksl_pkg::ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue_request(ksl_pkg::ACT_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(ksl_pkg::ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(ksl_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(ksl_pkg::ACT_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        issue_request(ksl_pkg::ACT_INSERT, 32'h0000_0000, 32'h1234_5678);
        issue_request(ksl_pkg::ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(ksl_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(ksl_pkg::ACT_LOOKUP, 32'h1234_5678, 32'h0000_0000);
        issue_request(ksl_pkg::ACT_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(ksl_pkg::ACT_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000);
        issue_request(ksl_pkg::ACT_DELETE, 32'h5A5A_5A5A, 32'h0000_0000);
        issue_request(ksl_pkg::ACT_DELETE, 32'h5A5A_5A5A, 32'h0000_0000);
        issue_request(ksl_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(ksl_pkg::ACT_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(ACT_UNUSED, 32'h0000_0000, 32'h0000_0000);

        // alternate fill and drain phases so the table swings between empty and full
        ins_cursor = 0;
        del_cursor = 0;
        filling    = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_LEN == 0)
                filling = ~filling;
            no_idle = (i >= 900 && i < 1200);
            roll = $urandom_range(99);
            if (roll < 5)
                act = ACT_UNUSED;
            else if (roll < 25)
                act = ksl_pkg::ACT_LOOKUP;
            else if (roll < 85)
                act = filling ? ksl_pkg::ACT_INSERT : ksl_pkg::ACT_DELETE;
            else
                act = filling ? ksl_pkg::ACT_DELETE : ksl_pkg::ACT_INSERT;
            roll = $urandom_range(99);
            case (act)
                ksl_pkg::ACT_INSERT: begin
                    if (roll < 80) begin
                        k = key_pool[ins_cursor];
                        ins_cursor = (ins_cursor + 1) % POOL_SIZE;
                    end else if (roll < 95)
                        k = key_pool[$urandom_range(POOL_SIZE-1)];
                    else
                        k = $urandom;
                end
                ksl_pkg::ACT_DELETE: begin
                    if (roll < 70) begin
                        k = key_pool[del_cursor];
                        del_cursor = (del_cursor + 1) % POOL_SIZE;
                    end else if (roll < 90)
                        k = key_pool[$urandom_range(POOL_SIZE-1)];
                    else
                        k = $urandom;
                end
                ksl_pkg::ACT_LOOKUP:
                    k = (roll < 85) ? key_pool[$urandom_range(POOL_SIZE-1)] : $urandom;
                default:
                    k = $urandom;
            endcase
            issue_request(act, k, $urandom);
        end
        no_idle = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d requests: %0d insert, %0d lookup, %0d delete, %0d unused code",
                 action_seen[0] + action_seen[1] + action_seen[2] + action_seen[3],
                 action_seen[ksl_pkg::ACT_INSERT], action_seen[ksl_pkg::ACT_LOOKUP],
                 action_seen[ksl_pkg::ACT_DELETE], action_seen[ACT_UNUSED]);
        $display("responses: %0d ok, %0d full, %0d duplicate, %0d not found",
                 status_seen[ksl_pkg::ST_OK], status_seen[ksl_pkg::ST_FULL],
                 status_seen[ksl_pkg::ST_DUP], status_seen[ksl_pkg::ST_MISSING]);
        if (fail_count == 0)
            $display("keyed_sequential_list_table_tb: clean");
        else
            $display("keyed_sequential_list_table_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ksl_pkg.sv
rtl/ksl_ram.sv
rtl/ksl_engine.sv
rtl/keyed_sequential_list_table.sv
sim/keyed_sequential_list_table_checker.sv
sim/keyed_sequential_list_table_tb.sv
